FILE: hdl/vkvfl_pkg.sv
// Shared constants for the versioned key-value floor lookup block.
// Holds the word layouts, opcodes and status codes; no dependencies.
package vkvfl_pkg;

	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 32;
	localparam int TIME_W   = 31;
	localparam int STATUS_W = 2;

	// input word layout: key, value, time, padded to bytes
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 40;

	localparam logic OP_STORE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_KEYS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_HIST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TIME_ORDER = 2'd3;

endpackage

FILE: hdl/versioned_key_value_floor_lookup.sv
// Top level of the versioned key-value table with floor lookup by time.
// Depends on vkvfl_pkg for word layouts, opcodes and status codes.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   s_tuser: opcode; s_tdata: key, value, time
//   m_*      out  m_tvalid/m_tready   m_tdata: found, result_value, status
//
// Flow: one word at a time; the sequencer returns to idle before it takes the next word.
// The slot scan compares each key from a registered read while the next read is issued;
// a missing key is known once the last slot has been compared.
// Reset: arst_n clears the slot-in-use bits, the sequencer and the output valid;
// memories are not cleared, their unwritten entries are never used.
// Stalls: s_tready is high only while idle; a finished result waits in the output
// register while the next input word is taken.
module versioned_key_value_floor_lookup #(
	parameter int KEY_SLOTS     = 16,
	parameter int HISTORY_DEPTH = 64,
	parameter int KEY_BITS      = 32,
	parameter int VALUE_BITS    = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// fields from bit 0: key_word[31:0], value_word[63:32], time_stamp[94:64], pad
	input  logic [vkvfl_pkg::IN_DATA_W-1:0] s_tdata,
	// fields from bit 0: opcode
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// fields from bit 0: found[0], result_value[32:1], status[34:33], pad
	output logic [vkvfl_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int SLOT_W   = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int CNT_W    = $clog2(HISTORY_DEPTH + 1);
	localparam int HA_W     = (KEY_SLOTS * HISTORY_DEPTH > 1) ?
	                          $clog2(KEY_SLOTS * HISTORY_DEPTH) : 1;
	localparam int HIST_N   = KEY_SLOTS * HISTORY_DEPTH;
	localparam int OUT_PAD  = vkvfl_pkg::OUT_DATA_W - 1 - vkvfl_pkg::VALUE_W
	                          - vkvfl_pkg::STATUS_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(KEY_SLOTS - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SCAN   = 4'd1;
	localparam logic [3:0] S_BASE   = 4'd2;
	localparam logic [3:0] S_CNT    = 4'd3;
	localparam logic [3:0] S_LAST   = 4'd4;
	localparam logic [3:0] S_WRITE  = 4'd5;
	localparam logic [3:0] S_BS_RD  = 4'd6;
	localparam logic [3:0] S_BS_CHK = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;

	// latched input word
	logic                          op_q;
	logic [KEY_BITS-1:0]           key_q;
	logic [VALUE_BITS-1:0]         val_in_q;
	logic [vkvfl_pkg::TIME_W-1:0]  time_q;

	// slot scan
	logic [KEY_SLOTS-1:0] slot_used_q;
	logic [SLOT_W-1:0]    scan_q;
	logic                 issue_q;
	logic                 cmp_valid_s1;
	logic [SLOT_W-1:0]    cmp_idx_s1;
	logic [SLOT_W-1:0]    free_q;
	logic                 free_found_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 new_q;

	// history access
	logic [HA_W-1:0]  base_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hip1_q;
	logic [CNT_W-1:0] mid_q;

	// working result
	logic                           hit_q;
	logic [VALUE_BITS-1:0]          res_val_q;
	logic [vkvfl_pkg::STATUS_W-1:0] res_status_q;

	// output register
	logic                           m_tvalid_q;
	logic                           out_found_q;
	logic [vkvfl_pkg::VALUE_W-1:0]  out_value_q;
	logic [vkvfl_pkg::STATUS_W-1:0] out_status_q;

	// memories and their registered read data
	logic [KEY_BITS-1:0]          slot_key_mem [KEY_SLOTS];
	logic [CNT_W-1:0]             count_mem    [KEY_SLOTS];
	logic [vkvfl_pkg::TIME_W-1:0] hist_time_mem  [HIST_N];
	logic [VALUE_BITS-1:0]        hist_value_mem [HIST_N];
	logic [KEY_BITS-1:0]          key_rd_q;
	logic [CNT_W-1:0]             cnt_rd_q;
	logic [vkvfl_pkg::TIME_W-1:0] time_rd_q;
	logic [VALUE_BITS-1:0]        value_rd_q;

	logic              in_fire;
	logic              out_load;
	logic              cmp_used;
	logic              cmp_match;
	logic [CNT_W-1:0]  cnt_now;
	logic [CNT_W-1:0]  mid;
	logic [CNT_W-1:0]  hidx;
	logic [HA_W-1:0]   hist_raddr;
	logic [HA_W-1:0]   hist_waddr;
	logic              bs_le;
	logic [CNT_W-1:0]  lo_next;
	logic [CNT_W-1:0]  hip1_next;

	assign s_tready = (state_q == S_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	assign cmp_used  = slot_used_q[cmp_idx_s1];
	assign cmp_match = cmp_valid_s1 && cmp_used && (key_rd_q == key_q);

	// a fresh slot starts with an empty history
	assign cnt_now = new_q ? '0 : cnt_rd_q;

	// upper middle of [lo, hip1 - 1]
	assign mid  = lo_q + ((hip1_q - lo_q) >> 1);
	assign hidx = (state_q == S_CNT) ? (cnt_now - CNT_W'(1)) : mid;
	assign hist_raddr = base_q + HA_W'(hidx);
	assign hist_waddr = base_q + HA_W'(cnt_q);

	assign bs_le     = (time_rd_q <= time_q);
	assign lo_next   = bs_le ? (mid_q + CNT_W'(1)) : lo_q;
	assign hip1_next = bs_le ? hip1_q : mid_q;

	// key slot memory: scanned one entry a cycle
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE && new_q) begin
			slot_key_mem[slot_q] <= key_q;
		end
		key_rd_q <= slot_key_mem[scan_q];
	end

	// history length per slot
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			count_mem[slot_q] <= cnt_q + CNT_W'(1);
		end
		cnt_rd_q <= count_mem[slot_q];
	end

	// history entries, one row of HISTORY_DEPTH per slot
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			hist_time_mem[hist_waddr]  <= time_q;
			hist_value_mem[hist_waddr] <= val_in_q;
		end
		time_rd_q  <= hist_time_mem[hist_raddr];
		value_rd_q <= hist_value_mem[hist_raddr];
	end

	// input latch and working payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= s_tuser;
			key_q    <= KEY_BITS'(s_tdata[31:0]);
			val_in_q <= VALUE_BITS'(s_tdata[63:32]);
			time_q   <= s_tdata[94:64];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_used_q  <= '0;
			issue_q      <= 1'b0;
			cmp_valid_s1 <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						scan_q       <= '0;
						issue_q      <= 1'b1;
						cmp_valid_s1 <= 1'b0;
						free_found_q <= 1'b0;
						hit_q        <= 1'b0;
						res_val_q    <= '0;
						res_status_q <= vkvfl_pkg::ST_OK;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue the next key read while comparing the previous one
					cmp_valid_s1 <= issue_q;
					cmp_idx_s1   <= scan_q;
					if (issue_q) begin
						if (scan_q == LAST_SLOT) begin
							issue_q <= 1'b0;
						end else begin
							scan_q <= scan_q + SLOT_W'(1);
						end
					end
					if (cmp_valid_s1) begin
						if (cmp_match) begin
							slot_q       <= cmp_idx_s1;
							new_q        <= 1'b0;
							issue_q      <= 1'b0;
							cmp_valid_s1 <= 1'b0;
							state_q      <= S_BASE;
						end else begin
							if (!cmp_used && !free_found_q) begin
								free_q       <= cmp_idx_s1;
								free_found_q <= 1'b1;
							end
							if (cmp_idx_s1 == LAST_SLOT) begin
								cmp_valid_s1 <= 1'b0;
								if (op_q == vkvfl_pkg::OP_LOOKUP) begin
									state_q <= S_DONE;
								end else if (free_found_q || !cmp_used) begin
									slot_q  <= free_found_q ? free_q : cmp_idx_s1;
									new_q   <= 1'b1;
									state_q <= S_BASE;
								end else begin
									res_status_q <= vkvfl_pkg::ST_KEYS_FULL;
									state_q      <= S_DONE;
								end
							end
						end
					end
				end
				S_BASE: begin
					// count read is in flight; form the history row base
					base_q  <= HA_W'(slot_q * HISTORY_DEPTH);
					state_q <= S_CNT;
				end
				S_CNT: begin
					cnt_q  <= cnt_now;
					lo_q   <= '0;
					hip1_q <= cnt_now;
					if (op_q == vkvfl_pkg::OP_STORE) begin
						if (cnt_now == FULL_CNT) begin
							res_status_q <= vkvfl_pkg::ST_HIST_FULL;
							state_q      <= S_DONE;
						end else if (cnt_now == '0) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_LAST;
						end
					end else if (cnt_now == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_BS_RD;
					end
				end
				S_LAST: begin
					if (time_q <= time_rd_q) begin
						res_status_q <= vkvfl_pkg::ST_TIME_ORDER;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (new_q) begin
						slot_used_q[slot_q] <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_BS_RD: begin
					mid_q   <= mid;
					state_q <= S_BS_CHK;
				end
				S_BS_CHK: begin
					if (bs_le) begin
						hit_q     <= 1'b1;
						res_val_q <= value_rd_q;
					end
					lo_q    <= lo_next;
					hip1_q  <= hip1_next;
					state_q <= (lo_next < hip1_next) ? S_BS_RD : S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q  <= hit_q;
			out_value_q  <= hit_q ? vkvfl_pkg::VALUE_W'(res_val_q) : '0;
			out_status_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {OUT_PAD'(0), out_status_q, out_value_q, out_found_q};

endmodule

FILE: hdl/vkvfl_checker.sv
// Port-level checks for versioned_key_value_floor_lookup, bound to the top level.
// Depends on vkvfl_pkg for the result word layout and status codes.
module vkvfl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [vkvfl_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic                           found;
	logic [vkvfl_pkg::VALUE_W-1:0]  value;
	logic [vkvfl_pkg::STATUS_W-1:0] status;

	assign found  = m_tdata[0];
	assign value  = m_tdata[32:1];
	assign status = m_tdata[34:33];

	// the sequencer is not ready in the cycle after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accepted word");

	a_hit_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && found |-> status == vkvfl_pkg::ST_OK)
		else $error("lookup hit with nonzero status");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !found |-> value == '0)
		else $error("nonzero value without a hit");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[vkvfl_pkg::OUT_DATA_W-1:35] == '0)
		else $error("result padding not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

endmodule

bind versioned_key_value_floor_lookup vkvfl_checker u_vkvfl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: verif/versioned_key_value_floor_lookup_tb.sv
// Testbench for versioned_key_value_floor_lookup: a directed table of store/lookup
// words, then random traffic, each result checked against an in-bench floor predictor or a typed-in result.
// Depends on vkvfl_pkg and the block's RTL only.
module versioned_key_value_floor_lookup_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_SLOTS  = 16;
	localparam int HIST_DEPTH = 64;
	localparam int N_DIR      = 22;
	localparam int N_RANDOM   = 2000;
	localparam int POOL_SIZE  = 16;
	localparam int HOT_KEY    = 4;      // pool entry that gets the most traffic
	localparam int QUIET_LO   = 900;    // word/result window with no idling on either side
	localparam int QUIET_HI   = 1200;
	localparam int HOLD_AT    = 300;    // result count that starts the long receiver hold
	localparam int HOLD_LEN   = 400;
	localparam int DRAIN      = 64;     // wait for stray results after the last expected one
	localparam logic [vkvfl_pkg::TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic                          op;
		logic [vkvfl_pkg::KEY_W-1:0]   key;
		logic [vkvfl_pkg::VALUE_W-1:0] val;
		logic [vkvfl_pkg::TIME_W-1:0]  ts;
	} kv_word_t;

	typedef struct packed {
		logic                           found;
		logic [vkvfl_pkg::VALUE_W-1:0]  value;
		logic [vkvfl_pkg::STATUS_W-1:0] status;
	} kv_result_t;

	// directed row: input word, then the result typed in where it is obvious
	typedef struct packed {
		logic                           op;
		logic [vkvfl_pkg::KEY_W-1:0]    key;
		logic [vkvfl_pkg::VALUE_W-1:0]  val;
		logic [vkvfl_pkg::TIME_W-1:0]   ts;
		logic                           typed_exp;
		logic                           found;
		logic [vkvfl_pkg::VALUE_W-1:0]  value;
		logic [vkvfl_pkg::STATUS_W-1:0] status;
	} dir_row_t;

	logic                             clk      = 1'b0;
	logic                             arst_n   = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [vkvfl_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
	logic                             s_tuser  = 1'b0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [vkvfl_pkg::OUT_DATA_W-1:0] m_tdata;

	// predictor copy of the table; bit/int arrays start at zero like the block after reset
	logic [vkvfl_pkg::KEY_W-1:0]   slot_key_q [KEY_SLOTS];
	bit                            slot_busy  [KEY_SLOTS];
	int                            hist_len   [KEY_SLOTS];
	logic [vkvfl_pkg::TIME_W-1:0]  hist_ts    [KEY_SLOTS][HIST_DEPTH];
	logic [vkvfl_pkg::VALUE_W-1:0] hist_val   [KEY_SLOTS][HIST_DEPTH];

	logic [vkvfl_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
	kv_result_t                  pending_q [$];    // expected results, oldest first
	int                          errors = 0;

	versioned_key_value_floor_lookup u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// hold reset low from time zero, then release it for good
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#1_500_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int slot_of(input logic [vkvfl_pkg::KEY_W-1:0] key);
		for (int s = 0; s < KEY_SLOTS; s++)
			if (slot_busy[s] && slot_key_q[s] == key)
				return s;
		return -1;
	endfunction

	// Apply one word to the predictor table and return the result it must produce.
	function automatic kv_result_t apply_kv_word(input kv_word_t w);
		kv_result_t r;
		int         s;
		int         n;
		r = '0;
		s = slot_of(w.key);
		if (w.op == vkvfl_pkg::OP_LOOKUP) begin
			// times rise strictly, so the newest entry not above the query is the floor
			if (s >= 0)
				for (int i = hist_len[s] - 1; i >= 0; i--)
					if (hist_ts[s][i] <= w.ts) begin
						r.found = 1'b1;
						r.value = hist_val[s][i];
						break;
					end
			return r;
		end
		if (s < 0) begin
			for (int f = 0; f < KEY_SLOTS && s < 0; f++)
				if (!slot_busy[f])
					s = f;
			if (s < 0) begin
				r.status = vkvfl_pkg::ST_KEYS_FULL;
				return r;
			end
			slot_busy[s]  = 1'b1;
			slot_key_q[s] = w.key;
			hist_len[s]   = 0;
		end
		n = hist_len[s];
		// history full wins over a bad timestamp
		if (n >= HIST_DEPTH)
			r.status = vkvfl_pkg::ST_HIST_FULL;
		else if (n > 0 && w.ts <= hist_ts[s][n-1])
			r.status = vkvfl_pkg::ST_TIME_ORDER;
		else begin
			hist_ts[s][n]  = w.ts;
			hist_val[s][n] = w.val;
			hist_len[s]    = n + 1;
			r.status       = vkvfl_pkg::ST_OK;
		end
		return r;
	endfunction

	// Mostly well-formed traffic over a small key pool: rising store times, lookups
	// near stored times. Some stores go out of order; fresh keys show up as noise,
	// more of them once the slot table is full.
	function automatic kv_word_t random_kv_word();
		kv_word_t                     w;
		int                           s;
		int                           n;
		int                           pick;
		int unsigned                  t;
		logic [vkvfl_pkg::TIME_W-1:0] last;
		bit                           full;
		full = 1'b1;
		for (int f = 0; f < KEY_SLOTS; f++)
			if (!slot_busy[f])
				full = 1'b0;
		pick = $urandom_range(99);
		if (pick < (full ? 8 : 1))
			w.key = $urandom();
		else if (pick < 28)
			w.key = key_pool[HOT_KEY];
		else
			w.key = key_pool[$urandom_range(POOL_SIZE - 1)];
		w.op  = ($urandom_range(99) < 45) ? vkvfl_pkg::OP_LOOKUP : vkvfl_pkg::OP_STORE;
		w.val = $urandom();
		w.ts  = vkvfl_pkg::TIME_W'($urandom());
		s = slot_of(w.key);
		n = (s >= 0) ? hist_len[s] : 0;
		if (n == 0) begin
			if (w.op == vkvfl_pkg::OP_STORE)
				w.ts = vkvfl_pkg::TIME_W'($urandom_range(1 << 20));
			return w;
		end
		last = hist_ts[s][n-1];
		if (w.op == vkvfl_pkg::OP_STORE) begin
			if ($urandom_range(99) < 12) begin
				// equal to or below the newest stored time
				t    = $urandom_range((32'(last) < 1000) ? 32'(last) : 32'd1000);
				w.ts = last - vkvfl_pkg::TIME_W'(t);
			end else begin
				t    = ($urandom_range(3) == 0) ? 1 : $urandom_range(1 << 24, 1);
				t    = 32'(last) + t;
				w.ts = (t > 32'(TIME_MAX)) ? TIME_MAX : vkvfl_pkg::TIME_W'(t);
			end
		end else begin
			case ($urandom_range(7))
			0: begin
				// keep the wide random query
			end
			1: w.ts = $urandom_range(1) ? TIME_MAX : '0;
			2: w.ts = (hist_ts[s][0] == 0) ? '0 : hist_ts[s][0] - 1'b1;
			default: begin
				// one below, at, or one above a stored time
				t = 32'(hist_ts[s][$urandom_range(n - 1)]) + $urandom_range(2);
				if (t > 0)
					t = t - 1;
				w.ts = (t > 32'(TIME_MAX)) ? TIME_MAX : vkvfl_pkg::TIME_W'(t);
			end
			endcase
		end
		return w;
	endfunction

	// sender: walk the directed table, then the random words
	initial begin
		dir_row_t    dir_tab [N_DIR];
		kv_word_t    w;
		kv_result_t  r;
		int          n_lookup;
		int          n_hit;
		int          store_status [4];

		n_lookup = 0;
		n_hit    = 0;
		foreach (store_status[k])
			store_status[k] = 0;

		dir_tab[0]  = '{vkvfl_pkg::OP_LOOKUP, 32'h0, 32'hDEADBEEF, 31'd0,
			1'b1, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[1]  = '{vkvfl_pkg::OP_STORE, 32'h0, 32'hFFFFFFFF, 31'd0,
			1'b1, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[2]  = '{vkvfl_pkg::OP_STORE, 32'h0, 32'h0, 31'd0,
			1'b1, 1'b0, 32'h0, vkvfl_pkg::ST_TIME_ORDER};
		dir_tab[3]  = '{vkvfl_pkg::OP_LOOKUP, 32'h0, 32'h0, 31'd0,
			1'b1, 1'b1, 32'hFFFFFFFF, vkvfl_pkg::ST_OK};
		dir_tab[4]  = '{vkvfl_pkg::OP_STORE, 32'hFFFFFFFF, 32'h0, TIME_MAX,
			1'b1, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[5]  = '{vkvfl_pkg::OP_STORE, 32'hFFFFFFFF, 32'h12345678, TIME_MAX,
			1'b1, 1'b0, 32'h0, vkvfl_pkg::ST_TIME_ORDER};
		dir_tab[6]  = '{vkvfl_pkg::OP_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFE,
			1'b1, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[7]  = '{vkvfl_pkg::OP_LOOKUP, 32'hFFFFFFFF, 32'h0, TIME_MAX,
			1'b1, 1'b1, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[8]  = '{vkvfl_pkg::OP_STORE, 32'h0, 32'h12345678, 31'd100,
			1'b1, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[9]  = '{vkvfl_pkg::OP_STORE, 32'h0, 32'h0, 31'd50,
			1'b1, 1'b0, 32'h0, vkvfl_pkg::ST_TIME_ORDER};
		dir_tab[10] = '{vkvfl_pkg::OP_LOOKUP, 32'h0, 32'h0, 31'd99,
			1'b0, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[11] = '{vkvfl_pkg::OP_LOOKUP, 32'h0, 32'h0, 31'd100,
			1'b0, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[12] = '{vkvfl_pkg::OP_LOOKUP, 32'h0, 32'h0, TIME_MAX,
			1'b0, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[13] = '{vkvfl_pkg::OP_STORE, 32'h0, 32'hA5A5A5A5, 31'd101,
			1'b0, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[14] = '{vkvfl_pkg::OP_LOOKUP, 32'h0, 32'h0, 31'd100,
			1'b0, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[15] = '{vkvfl_pkg::OP_LOOKUP, 32'h0, 32'h0, 31'd101,
			1'b0, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[16] = '{vkvfl_pkg::OP_LOOKUP, 32'h5A5A5A5A, 32'h0, TIME_MAX,
			1'b1, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[17] = '{vkvfl_pkg::OP_STORE, 32'h5A5A5A5A, 32'h5A5A5A5A, 31'd1,
			1'b1, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[18] = '{vkvfl_pkg::OP_LOOKUP, 32'h5A5A5A5A, 32'h0, 31'd0,
			1'b1, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[19] = '{vkvfl_pkg::OP_STORE, 32'h80000001, 32'hFFFFFFFF, 31'h40000000,
			1'b0, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[20] = '{vkvfl_pkg::OP_LOOKUP, 32'h80000001, 32'h0, 31'h3FFFFFFF,
			1'b0, 1'b0, 32'h0, vkvfl_pkg::ST_OK};
		dir_tab[21] = '{vkvfl_pkg::OP_LOOKUP, 32'h80000001, 32'h0, 31'h40000000,
			1'b0, 1'b0, 32'h0, vkvfl_pkg::ST_OK};

		// the directed keys stay in the pool so random traffic builds on their histories
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFFFFFF;
		key_pool[2] = 32'h5A5A5A5A;
		key_pool[3] = 32'h80000001;
		for (int k = 4; k < POOL_SIZE; k++)
			key_pool[k] = $urandom();

		while (!arst_n)
			@(posedge clk);

		for (int i = 0; i < N_DIR + N_RANDOM; i++) begin
			if (i < N_DIR) begin
				w.op  = dir_tab[i].op;
				w.key = dir_tab[i].key;
				w.val = dir_tab[i].val;
				w.ts  = dir_tab[i].ts;
			end else
				w = random_kv_word();
			// idle now and then, except inside the quiet window
			if (i < QUIET_LO || i >= QUIET_HI)
				while ($urandom_range(99) < 23) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
				end
			s_tvalid <= 1'b1;
			s_tuser  <= w.op;
			s_tdata  <= {1'b0, w.ts, w.val, w.key};
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			// word taken at this edge: advance the predictor
			r = apply_kv_word(w);
			if (i < N_DIR && dir_tab[i].typed_exp) begin
				r.found  = dir_tab[i].found;
				r.value  = dir_tab[i].value;
				r.status = dir_tab[i].status;
			end
			pending_q.insert(pending_q.size(), r);
			if (w.op == vkvfl_pkg::OP_LOOKUP) begin
				n_lookup++;
				if (r.found)
					n_hit++;
			end else
				store_status[r.status]++;
		end
		s_tvalid <= 1'b0;

		while (pending_q.size() != 0)
			@(posedge clk);
		// let any stray result show up before the verdict
		repeat (DRAIN) @(posedge clk);

		$display("run covered %0d words: %0d lookups (%0d hits), %0d stores kept",
			N_DIR + N_RANDOM, n_lookup, n_hit, store_status[vkvfl_pkg::ST_OK]);
		$display("stores dropped: %0d key table full, %0d history full, %0d out of order",
			store_status[vkvfl_pkg::ST_KEYS_FULL], store_status[vkvfl_pkg::ST_HIST_FULL],
			store_status[vkvfl_pkg::ST_TIME_ORDER]);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// receiver: check each result word, then pick next cycle's ready
	int rx_count  = 0;
	int hold_left = 0;

	always @(posedge clk) begin
		kv_result_t got;
		kv_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			// m_tdata from bit 0: found, result_value, status
			got.found  = m_tdata[0];
			got.value  = m_tdata[32:1];
			got.status = m_tdata[34:33];
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result found=%0b value=%h status=%0d",
					$time, got.found, got.value, got.status);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (got.found !== want.found) begin
					$display("%0t: found expected %0b actual %0b",
						$time, want.found, got.found);
					errors++;
				end
				if (got.value !== want.value) begin
					$display("%0t: result_value expected %h actual %h",
						$time, want.value, got.value);
					errors++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, got.status);
					errors++;
				end
			end
			rx_count++;
			// back-pressure once for long enough that the block fills and stalls its input
			if (rx_count == HOLD_AT)
				hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_count >= QUIET_LO && rx_count < QUIET_HI)
			m_tready <= 1'b1;
		else
			m_tready <= ($urandom_range(99) >= 23);
	end

endmodule
